/* src/fpr_pkg.sv */
// Package for the exact binary64 remainder block.
// Holds request/result payload types and binary64 constants; no dependencies.
package fpr_pkg;

  typedef struct packed {
    logic        action;
    logic [63:0] dividend_bits;
    logic [63:0] divisor_bits;
  } fpr_req_t;

  typedef struct packed {
    logic [63:0] result_bits;
    logic [3:0]  quotient_low;
    logic        invalid;
  } fpr_rsp_t;

  localparam logic [63:0] QnanBits = 64'h7ff8000000000000;
  localparam logic [63:0] SignBit  = 64'h8000000000000000;
  localparam logic [63:0] MagMask  = 64'h7fffffffffffffff;
  localparam logic [10:0] ExpAll   = 11'h7ff;
  localparam logic [51:0] MantMask = 52'hfffffffffffff;

endpackage

/* src/fpr_divstep.sv */
// One shift-subtract step of the restoring division, the shared unit.
// Depends on nothing but its ports.
module fpr_divstep (
  input  logic [54:0] rem_i,
  input  logic [54:0] div_i,
  input  logic        shift_i,
  output logic [54:0] rem_o,
  output logic        bit_o
);
  logic [54:0] diff;

  // Compare and subtract, then shift for the next quotient bit while shift_i is set.
  always_comb begin
    bit_o = (rem_i >= div_i);
    diff  = bit_o ? (rem_i - div_i) : rem_i;
    rem_o = shift_i ? {diff[53:0], 1'b0} : diff;
  end
endmodule

/* src/fp_exact_remainder.sv */
// Top level of the exact binary64 remainder (fmod / IEEE remainder).
// Depends on fpr_pkg and fpr_divstep.
//
//  Channel | Direction | Handshake                | Payload
//  req     | in        | req_valid_i/req_ready_o  | fpr_req_t
//  rsp     | out       | rsp_valid_o/rsp_ready_i  | fpr_rsp_t
//
// A finite request is normalized (StNorm), divided (StDiv), rounded (StRnd) and
// packed (StPack) before it is offered, unless StNorm finds the dividend below
// half the divisor. The shift-subtract loop takes one quotient bit per cycle from
// fpr_divstep; normalizing a subnormal operand or repacking a small remainder
// shifts one bit a cycle; a special request is offered in the next cycle.
// Reset clears the sequencer; no request is taken until the result is taken.
module fp_exact_remainder
  import fpr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  fpr_req_t req_i,
  output logic     rsp_valid_o,
  input  logic     rsp_ready_i,
  output fpr_rsp_t rsp_o
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StNorm = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StRnd  = 3'd3;
  localparam logic [2:0] StPack = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0]  state_q, state_d;
  logic        near_q;
  logic [63:0] xb_q, yb_q;
  logic [54:0] mx_q, my_q;
  logic [12:0] ex_q, ey_q;
  logic [12:0] cnt_q;
  logic [2:0]  q_q;
  logic [63:0] rsign_q;
  fpr_rsp_t    rsp_q;

  logic [54:0] st_rem;
  logic        st_bit;

  fpr_divstep u_step (
    .rem_i(mx_q), .div_i(my_q), .shift_i(cnt_q != 13'd0),
    .rem_o(st_rem), .bit_o(st_bit)
  );

  // Operand classification.
  logic [10:0] xe, ye;
  logic xnan, ynan, xinf, yinf, yzero, xzero;
  always_comb begin
    xe    = req_i.dividend_bits[62:52];
    ye    = req_i.divisor_bits[62:52];
    xnan  = xe == ExpAll && req_i.dividend_bits[51:0] != 52'd0;
    ynan  = ye == ExpAll && req_i.divisor_bits[51:0] != 52'd0;
    xinf  = xe == ExpAll && req_i.dividend_bits[51:0] == 52'd0;
    yinf  = ye == ExpAll && req_i.divisor_bits[51:0] == 52'd0;
    yzero = (req_i.divisor_bits & MagMask) == 64'd0;
    xzero = (req_i.dividend_bits & MagMask) == 64'd0;
  end

  assign req_ready_o = (state_q == StIdle);
  assign rsp_valid_o = (state_q == StOut);
  assign rsp_o       = rsp_q;

  logic [54:0] twice;
  assign twice = {mx_q[53:0], 1'b0};

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (req_valid_i) state_d = (xnan || ynan || xinf || yzero || yinf || xzero)
                                         ? StOut : StNorm;
      StNorm: begin
        if (mx_q[52] && my_q[52]) begin
          if ($signed(ex_q) < $signed(ey_q) - 13'sd1) state_d = StOut;
          else state_d = StDiv;
        end
      end
      StDiv:  if (cnt_q == 13'd0) state_d = StRnd;
      StRnd:  state_d = StPack;
      StPack: begin
        if (mx_q == 55'd0 || ($signed(ey_q) >= 13'sd1 && (mx_q[52] || ey_q == 13'd1)))
          state_d = StOut;
      end
      StOut:  if (rsp_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        near_q <= req_i.action;
        xb_q   <= req_i.dividend_bits;
        yb_q   <= req_i.divisor_bits;
        q_q    <= 3'd0;
        rsign_q <= req_i.dividend_bits & SignBit;
        mx_q   <= {2'b0, xe != 11'd0, req_i.dividend_bits[51:0]};
        my_q   <= {2'b0, ye != 11'd0, req_i.divisor_bits[51:0]};
        ex_q   <= (xe == 11'd0) ? 13'd1 : {2'b0, xe};
        ey_q   <= (ye == 11'd0) ? 13'd1 : {2'b0, ye};
        rsp_q.quotient_low <= 4'd0;
        rsp_q.invalid      <= xnan || ynan || xinf || yzero;
        rsp_q.result_bits  <= (xnan || ynan || xinf || yzero) ? QnanBits
                                                              : req_i.dividend_bits;
      end
      StNorm: begin
        if (!mx_q[52]) begin
          mx_q <= {mx_q[53:0], 1'b0};
          ex_q <= ex_q - 13'd1;
        end
        if (!my_q[52]) begin
          my_q <= {my_q[53:0], 1'b0};
          ey_q <= ey_q - 13'd1;
        end
        if (mx_q[52] && my_q[52]) begin
          if (ex_q == ey_q - 13'd1) begin
            my_q <= {my_q[53:0], 1'b0};
            ey_q <= ex_q;
            cnt_q <= 13'd0;
          end else begin
            cnt_q <= ex_q - ey_q;
          end
        end
      end
      StDiv: begin
        mx_q  <= st_rem;
        q_q   <= {q_q[1:0], st_bit};
        cnt_q <= cnt_q - 13'd1;
      end
      StRnd: begin
        if (near_q && (twice > my_q || (twice == my_q && q_q[0]))) begin
          mx_q    <= my_q - mx_q;
          q_q     <= q_q + 3'd1;
          rsign_q <= rsign_q ^ SignBit;
        end
      end
      StPack: begin
        if (mx_q == 55'd0) begin
          rsp_q.result_bits <= xb_q & SignBit;
        end else if ($signed(ey_q) < 13'sd1) begin
          mx_q <= {1'b0, mx_q[54:1]};
          ey_q <= ey_q + 13'd1;
        end else if (!mx_q[52] && ey_q != 13'd1) begin
          mx_q <= {mx_q[53:0], 1'b0};
          ey_q <= ey_q - 13'd1;
        end else if (!mx_q[52]) begin
          rsp_q.result_bits <= rsign_q | {12'd0, mx_q[51:0]};
        end else begin
          rsp_q.result_bits <= rsign_q | {1'b0, ey_q[10:0], mx_q[51:0]};
        end
        if (near_q) begin
          rsp_q.quotient_low <= ((xb_q[63] ^ yb_q[63]) ? (4'd0 - {1'b0, q_q})
                                                       : {1'b0, q_q});
        end
      end
      default: ;
    endcase
  end

  // A result is offered only while no request is taken, holds while stalled, and an invalid result is a quiet NaN.
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_ready_o && rsp_valid_o)) else $error("ready and valid together");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("result changed while stalled");
  a_nan_q: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.invalid |-> rsp_o.quotient_low == 4'd0 &&
    rsp_o.result_bits == QnanBits) else $error("bad invalid result");
endmodule
